// ----- src/scnt_pkg.sv -----
// ----------------------------------------------------------------------------
// scnt_pkg
// Shared types and constants for the calibrate/normalize/trimmed-mean block.
// ----------------------------------------------------------------------------
package scnt_pkg;

  // Operation codes carried by each input item
  typedef enum logic [1:0] {
    OP_CAL_START  = 2'd0,
    OP_CAL_SAMPLE = 2'd1,
    OP_CAL_FINISH = 2'd2,
    OP_MEASURE    = 2'd3
  } op_e;

  localparam int SampleW = 16;
  localparam int RangeW  = 17;
  localparam int DivW    = 18;   // dividend width: sample - min
  localparam int CalMaxInit = 1;
  localparam int CalMinInit = 10;

  // Averaging window; the trimmed sum is divided by Window - 2 through a
  // reciprocal multiply, exact for magnitudes below 2**AvgMagW
  localparam int Window   = 5;
  localparam int WinDiv   = Window - 2;
  localparam int AvgMagW  = 17;  // |sum of the kept values| < 2**17
  localparam int AvgShift = 17;
  localparam int AvgRecip = (2 ** AvgShift + WinDiv - 1) / WinDiv;
  localparam int ProdW    = AvgMagW + AvgShift;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  // Control from sequencer to every lane
  typedef struct packed {
    logic  load;       // item accepted this cycle
    op_e   op;
    logic  div_start;  // launch normalization divider
    logic  div_done;   // quotient ready, fold into window
    logic  first;      // first item of the window
    logic  last;       // last item of the window
    logic  avg_start;  // capture trimmed sum for scaling
  } lane_ctrl_t;

endpackage

// ----- src/scnt_if.sv -----
// ----------------------------------------------------------------------------
// scnt_stream_if
// Valid/ready channel carrying one vector of signed samples and an opcode.
// ----------------------------------------------------------------------------
interface scnt_stream_if #(
  parameter int CHANNELS = 8
);
  import scnt_pkg::*;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            operation;
  logic signed [CHANNELS-1:0][SampleW-1:0] data;

  modport source (output valid, output operation, output data, input ready);
  modport sink   (input valid, input operation, input data, output ready);
endinterface

// ----- src/sensor_calibrate_normalize_trimmed_mean.sv -----
// ----------------------------------------------------------------------------
// sensor_calibrate_normalize_trimmed_mean
// Per-channel min/max calibration, normalization and windowed trimmed mean.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   operation, data[CHANNELS] (samples)
// out_if    out  data[CHANNELS] (averages), held in one output register
// Calibration items leave ready high.
// A measurement item holds ready low after its transfer while it goes through
// load, one quotient bit a cycle in each lane's divider, and fold into window.
// The window-closing item then captures the trimmed sum for the reciprocal
// scaling, then moves the result into the output register.
// The block waits on the sink only if the previous result is still unread
// when the next window closes. Reset is asynchronous; all lanes restart
// calibration defaults.
// ----------------------------------------------------------------------------
module sensor_calibrate_normalize_trimmed_mean
  import scnt_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  scnt_stream_if.sink   in_if,
  scnt_stream_if.source out_if
);
  localparam int SumW = 20;
  localparam int CntW = $clog2(Window);
  localparam int StW  = $clog2(SumW + 2);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q;
  logic [StW-1:0]  step_q;
  logic            avg_q;
  logic            ovalid_q;
  logic signed [CHANNELS-1:0][SampleW-1:0] smp_q, avg, odata_q;
  lane_ctrl_t ctrl;
  logic acc;
  logic oload;

  assign acc   = in_if.valid && in_if.ready;
  // Result moves into the output register once that register is free
  assign oload = (state_q == ST_OUT) && (!ovalid_q || out_if.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (acc && op_e'(in_if.operation) == OP_MEASURE) state_d = ST_DIV;
      ST_DIV:  if (step_q == '0 && avg_q) state_d = ST_OUT;
               else if (step_q == StW'(SumW + 1) && cnt_q != CntW'(Window - 1))
                 state_d = ST_IDLE;
      ST_OUT:  if (oload) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_if.ready    = (state_q == ST_IDLE);
    out_if.valid   = ovalid_q;
    ctrl.load      = acc;
    ctrl.op        = op_e'(in_if.operation);
    ctrl.div_start = (state_q == ST_DIV) && step_q == '0 && !avg_q;
    ctrl.div_done  = (state_q == ST_DIV) && step_q == StW'(SumW + 1) && !avg_q;
    ctrl.first     = (cnt_q == '0);
    ctrl.last      = (cnt_q == CntW'(Window - 1));
    ctrl.avg_start = (state_q == ST_DIV) && step_q == '0 && avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; step_q <= '0; avg_q <= 1'b0;
      ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      state_q <= state_d;
      if (acc) step_q <= '0;
      else if (state_q == ST_DIV)
        step_q <= (step_q == StW'(SumW + 1)) ? '0 : step_q + 1'b1;
      if (ctrl.div_done) begin
        if (ctrl.last) begin
          cnt_q <= '0; avg_q <= 1'b1;
        end else cnt_q <= cnt_q + 1'b1;
      end
      // Output register
      if (oload) begin
        ovalid_q <= 1'b1;
        odata_q  <= avg;
        avg_q    <= 1'b0;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) smp_q <= in_if.data;
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    scnt_lane #(.SumW(SumW)) u_lane (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .sample_i(acc ? in_if.data[g] : smp_q[g]), .avg_o(avg[g])
    );
  end

  assign out_if.data      = odata_q;
  assign out_if.operation = OP_MEASURE;

  // Checks
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> avg_q) else $error("result without window close");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !acc) else $error("accept while busy");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Window - 1)) else $error("window count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped or changed while stalled");
endmodule

// ----- src/scnt_div.sv -----
// ----------------------------------------------------------------------------
// scnt_div
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module scnt_div
  import scnt_pkg::*;
#(
  parameter int NW = 20,
  parameter int DW = 17
) (
  input  logic                 clk_i,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output logic signed [NW-1:0] quo_o
);
  logic [NW-1:0] mag_q, mag_d;
  logic [DW-1:0] dmag_q;
  logic [DW:0]   rem_q, rem_d;
  logic          neg_q;
  logic [DW:0]   trial;

  // Shift-subtract step
  always_comb begin
    trial = {rem_q[DW-1:0], mag_q[NW-1]};
    rem_d = trial;
    mag_d = {mag_q[NW-2:0], 1'b0};
    if (trial >= {1'b0, dmag_q}) begin
      rem_d    = trial - {1'b0, dmag_q};
      mag_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= num_i[NW-1] ? NW'(-num_i) : num_i;
      dmag_q <= den_i[DW-1] ? DW'(-den_i) : den_i;
      neg_q  <= num_i[NW-1] ^ den_i[DW-1];
      rem_q  <= '0;
    end else begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = neg_q ? NW'(-mag_q) : mag_q;
endmodule

// ----- src/scnt_lane.sv -----
// ----------------------------------------------------------------------------
// scnt_lane
// One channel: calibration tracking, normalization and window statistics.
// ----------------------------------------------------------------------------
module scnt_lane
  import scnt_pkg::*;
#(
  parameter int SumW = 20
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lane_ctrl_t                ctrl_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic signed [SampleW-1:0] avg_o
);
  logic signed [SampleW-1:0] max_q, min_q, wmax_q, wmin_q;
  logic signed [RangeW-1:0]  range_q;
  logic signed [SumW-1:0]    sum_q;
  logic signed [DivW-1:0]    num;
  logic signed [SampleW-1:0] n;
  logic signed [SumW-1:0]    tsum, aq;
  logic signed [SumW-1:0]    ndiv_quo;
  logic                      rz;
  logic [AvgMagW-1:0]        tmag_q;
  logic                      tneg_q;
  logic [ProdW-1:0]          prod;
  logic [AvgMagW-1:0]        qmag;

  assign num = DivW'(sample_i) - DivW'(min_q);
  assign rz  = (range_q == '0);

  scnt_div #(.NW(SumW), .DW(RangeW)) u_ndiv (
    .clk_i, .start_i(ctrl_i.div_start), .num_i(SumW'(num)),
    .den_i(range_q), .quo_o(ndiv_quo)
  );

  // Saturate normalized quotient
  always_comb begin
    if (rz) n = '0;
    else if (ndiv_quo > SumW'(32767)) n = 16'sh7fff;
    else if (ndiv_quo < -SumW'(32768)) n = -16'sh8000;
    else n = SampleW'(ndiv_quo);
  end

  // Trimmed sum: drop the window max and min
  assign tsum = sum_q - SumW'(wmax_q) - SumW'(wmin_q);

  // Calibration and window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= SampleW'(CalMaxInit);
      min_q <= SampleW'(CalMinInit);
      range_q <= '0;
      sum_q <= '0; wmax_q <= '0; wmin_q <= '0;
      tmag_q <= '0; tneg_q <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        unique case (ctrl_i.op)
          OP_CAL_START: begin
            max_q <= SampleW'(CalMaxInit);
            min_q <= SampleW'(CalMinInit);
          end
          OP_CAL_SAMPLE: begin
            if (max_q < sample_i) max_q <= sample_i;
            if (sample_i > 0 && min_q > sample_i) min_q <= sample_i;
          end
          OP_CAL_FINISH: range_q <= RangeW'(max_q) - RangeW'(min_q);
          OP_MEASURE: ;
          default: ;
        endcase
      end
      if (ctrl_i.div_done) begin
        if (ctrl_i.first) begin
          sum_q <= SumW'(n); wmax_q <= n; wmin_q <= n;
        end else begin
          sum_q <= sum_q + SumW'(n);
          if (wmax_q < n) wmax_q <= n;
          if (wmin_q > n) wmin_q <= n;
        end
      end
      // Sign and magnitude of the trimmed sum
      if (ctrl_i.avg_start) begin
        tneg_q <= tsum[SumW-1];
        tmag_q <= AvgMagW'(tsum[SumW-1] ? -tsum : tsum);
      end
    end
  end

  // Divide by Window - 2: reciprocal multiply, truncating toward zero
  assign prod = ProdW'(tmag_q) * ProdW'(AvgRecip);
  assign qmag = prod[ProdW-1:AvgShift];
  assign aq   = tneg_q ? -SumW'(qmag) : SumW'(qmag);

  always_comb begin
    if (aq > SumW'(32767)) avg_o = 16'sh7fff;
    else if (aq < -SumW'(32768)) avg_o = -16'sh8000;
    else avg_o = SampleW'(aq);
  end
endmodule
